### rtl/esib_pkg.sv
// shared types and constants of the edit script identity block
package esib_pkg;

    // fixed field widths
    localparam int GAP_W      = 24;
    localparam int CHAR_W     = 8;
    localparam int ID_W       = 17;
    localparam int MIN_LEN_W  = 24;
    localparam int KIND_W     = 2;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_IDENTITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH   = 1'b1;

    // result buffer of one request
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = 2;

    // divider step counter (one quotient bit per step)
    localparam int DIV_STEP_W  = 5;

    // edit operation codes
    typedef enum logic [KIND_W-1:0] {
        OP_PAIR  = 2'd0,
        OP_GAP_B = 2'd1,
        OP_GAP_A = 2'd2
    } op_kind_t;

    // result codes
    typedef enum logic [KIND_W-1:0] {
        RK_RUN     = 2'd0,
        RK_END     = 2'd1,
        RK_SUMMARY = 2'd2
    } res_kind_t;

    // walker sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK_PRE,
        ST_APPLY,
        ST_CHECK_POST,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

### rtl/esib_op_if.sv
// edit operation request channel
interface esib_op_if #(
    parameter int POSITION_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic [esib_pkg::KIND_W-1:0]   op_kind;
    logic [esib_pkg::GAP_W-1:0]    gap_length;
    logic [esib_pkg::CHAR_W-1:0]   char_a;
    logic [esib_pkg::CHAR_W-1:0]   char_b;
    logic [POSITION_BITS-1:0]      base_a;
    logic [POSITION_BITS-1:0]      base_b;
    logic [POSITION_BITS-1:0]      len_a;
    logic [POSITION_BITS-1:0]      len_b;
    logic                          new_alignment;

    modport source (
        output valid, op_kind, gap_length, char_a, char_b,
               base_a, base_b, len_a, len_b, new_alignment,
        input  ready
    );
    modport sink (
        input  valid, op_kind, gap_length, char_a, char_b,
               base_a, base_b, len_a, len_b, new_alignment,
        output ready
    );
endinterface

### rtl/esib_res_if.sv
// result request channel
interface esib_res_if #(
    parameter int POSITION_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic [esib_pkg::KIND_W-1:0]   result_kind;
    logic [POSITION_BITS:0]        pos_a;
    logic [POSITION_BITS:0]        pos_b;
    logic [esib_pkg::ID_W-1:0]     identity;
    logic                          accepted;
    logic                          last_of_run;

    modport source (
        output valid, result_kind, pos_a, pos_b, identity, accepted, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, result_kind, pos_a, pos_b, identity, accepted, last_of_run,
        output ready
    );
endinterface

### rtl/esib_cfg_if.sv
// configuration write channel
interface esib_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [esib_pkg::CFG_IDX_W-1:0]    index;
    logic [esib_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/edit_script_identity_and_blocks_core.sv
// top level of the edit script identity and aligned-run anchor block
//
// Channels: op takes one edit operation per request (aligned pair or gap);
// res returns run anchors, end anchors and the identity summary, with
// last_of_run marking the final result caused by one operation; cfg writes
// min_identity (index 0) and min_length (index 1), always ready.
// Sequence: an operation is accepted and passes through pre check, apply and
// post check, then hands out its results in turn as each is taken, or returns
// to idle when it has none; an operation ignored after the summary, or one
// that finds both sides already exhausted, skips apply and post check. An
// operation that closes the alignment also passes through the bit-serial
// divider, which produces one quotient bit per cycle over 17 bits. op.ready
// stays low from acceptance until every result of that operation is taken.
// Reset clears thresholds, offsets, counters and flags; no clearing pass.
// A stalled receiver holds res.valid and the result fields steady, and no
// new operation is taken until the stall ends and the last result is taken.
module edit_script_identity_and_blocks_core #(
    parameter int POSITION_BITS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    esib_op_if.sink      op,
    esib_res_if.source   res,
    esib_cfg_if.sink     cfg
);
    logic [esib_pkg::ID_W-1:0]       min_identity_reg;
    logic [esib_pkg::MIN_LEN_W-1:0]  min_length_reg;

    logic                            div_start;
    logic                            div_done;
    logic [POSITION_BITS:0]          div_matches;
    logic [POSITION_BITS+1:0]        div_others;
    logic [esib_pkg::ID_W-1:0]       div_quot;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_identity_reg <= '0;
            min_length_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                esib_pkg::REG_MIN_IDENTITY:
                    min_identity_reg <= cfg.data[esib_pkg::ID_W-1:0];
                esib_pkg::REG_MIN_LENGTH:
                    min_length_reg <= cfg.data[esib_pkg::MIN_LEN_W-1:0];
                default:
                    min_length_reg <= min_length_reg;
            endcase
        end
    end

    // edit script walker and sequencer
    esib_walk #(
        .POSITION_BITS (POSITION_BITS)
    ) u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .res          (res),
        .min_identity (min_identity_reg),
        .min_length   (min_length_reg),
        .div_start    (div_start),
        .div_matches  (div_matches),
        .div_others   (div_others),
        .div_done     (div_done),
        .div_quot     (div_quot)
    );

    // identity divider
    esib_div #(
        .POSITION_BITS (POSITION_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .match_cnt (div_matches),
        .others    (div_others),
        .done      (div_done),
        .quot      (div_quot)
    );

endmodule

### rtl/esib_div.sv
// iterative restoring divider for the Q1.16 identity ratio
module esib_div #(
    parameter int POSITION_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [POSITION_BITS:0]        match_cnt,
    input  logic [POSITION_BITS+1:0]      others,
    output logic                          done,
    output logic [esib_pkg::ID_W-1:0]     quot
);
    localparam int DW = POSITION_BITS + 3;
    localparam int RW = POSITION_BITS + 4;
    localparam int QW = esib_pkg::ID_W;

    logic                              run_reg;
    logic                              done_reg;
    logic [esib_pkg::DIV_STEP_W-1:0]   step_reg;
    logic [RW-1:0]                     rem_reg;
    logic [DW-1:0]                     dvs_reg;
    logic [QW-1:0]                     quo_reg;
    logic                              zero_reg;

    logic [DW-1:0]                     total;
    logic [RW-1:0]                     trial;
    logic                              fits;
    logic                              last_step;

    // divisor is matches plus others
    assign total     = DW'(match_cnt) + DW'(others);
    assign last_step = step_reg == esib_pkg::DIV_STEP_W'(QW - 1);

    // first step compares the bare numerator, later steps shift in a zero
    assign trial = (step_reg == '0) ? rem_reg : {rem_reg[RW-2:0], 1'b0};
    assign fits  = trial >= RW'(dvs_reg);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= run_reg && last_step;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                if (last_step)
                    run_reg <= 1'b0;
                step_reg <= step_reg + esib_pkg::DIV_STEP_W'(1);
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= RW'(match_cnt);
            dvs_reg  <= total;
            quo_reg  <= '0;
            zero_reg <= total == '0;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? (trial - RW'(dvs_reg)) : trial;
            quo_reg <= {quo_reg[QW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = zero_reg ? '0 : quo_reg;

endmodule

### rtl/esib_walk.sv
// edit script walker: counters, offsets, anchor and summary sequencer
module esib_walk #(
    parameter int POSITION_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    esib_op_if.sink                           op,
    esib_res_if.source                        res,
    input  logic [esib_pkg::ID_W-1:0]         min_identity,
    input  logic [esib_pkg::MIN_LEN_W-1:0]    min_length,
    output logic                              div_start,
    output logic [POSITION_BITS:0]            div_matches,
    output logic [POSITION_BITS+1:0]          div_others,
    input  logic                              div_done,
    input  logic [esib_pkg::ID_W-1:0]         div_quot
);
    localparam int P   = POSITION_BITS;
    localparam int PW  = P + 1;
    localparam int OCW = P + 2;
    localparam int GW  = esib_pkg::GAP_W;
    localparam int AW  = ((PW > GW) ? PW : GW) + 1;
    localparam int OAW = ((OCW > GW) ? OCW : GW) + 1;
    localparam int LW  = (P > esib_pkg::MIN_LEN_W) ? P : esib_pkg::MIN_LEN_W;
    localparam int CW  = esib_pkg::CNT_W;
    localparam int NR  = esib_pkg::MAX_RESULTS;

    esib_pkg::state_t state_reg, state_next;

    // latched operation
    logic [esib_pkg::KIND_W-1:0]  op_kind_reg, op_kind_next;
    logic [GW-1:0]                gap_reg, gap_next;
    logic                         chars_eq_reg, chars_eq_next;

    // alignment state
    logic [P-1:0]    base_a_reg, base_a_next, base_b_reg, base_b_next;
    logic [P-1:0]    len_a_reg, len_a_next, len_b_reg, len_b_next;
    logic [PW-1:0]   offset_a_reg, offset_a_next, offset_b_reg, offset_b_next;
    logic [PW-1:0]   match_reg, match_next;
    logic [OCW-1:0]  other_reg, other_next;
    logic            in_run_reg, in_run_next;
    logic            blocks_done_reg, blocks_done_next;
    logic            summary_done_reg, summary_done_next;

    // result buffer
    logic [CW-1:0]                cnt_reg, cnt_next, idx_reg, idx_next;
    logic [esib_pkg::KIND_W-1:0]  kind_buf [NR];
    logic [PW-1:0]                pa_buf   [NR];
    logic [PW-1:0]                pb_buf   [NR];
    logic [esib_pkg::ID_W-1:0]    ident_reg, ident_next;
    logic                         acc_reg, acc_next;
    logic                         push;
    logic [esib_pkg::KIND_W-1:0]  push_kind;

    // combinational helpers
    logic            ea, eb, start_sum, last_taken;
    logic [P+1:0]    pos_a_sum, pos_b_sum;
    logic [PW-1:0]   pos_a_now, pos_b_now;
    logic [GW-1:0]   amt_a, amt_b, amt_o;
    logic            inc_m;
    logic [AW-1:0]   sum_a, sum_b;
    logic [OAW-1:0]  sum_o;
    logic [PW-1:0]   offa_sat, offb_sat, match_sat;
    logic [OCW-1:0]  other_sat;

    // current positions, saturated
    assign pos_a_sum = (P + 2)'(base_a_reg) + (P + 2)'(offset_a_reg);
    assign pos_b_sum = (P + 2)'(base_b_reg) + (P + 2)'(offset_b_reg);
    assign pos_a_now = pos_a_sum[P+1] ? {PW{1'b1}} : pos_a_sum[PW-1:0];
    assign pos_b_now = pos_b_sum[P+1] ? {PW{1'b1}} : pos_b_sum[PW-1:0];

    // exhaustion tests
    assign ea        = offset_a_reg >= PW'(len_a_reg);
    assign eb        = offset_b_reg >= PW'(len_b_reg);
    assign start_sum = !summary_done_reg && ea && eb;

    // step amounts of the latched operation
    always_comb
    begin
        amt_a = '0;
        amt_b = '0;
        amt_o = '0;
        inc_m = 1'b0;
        case (op_kind_reg)
            esib_pkg::OP_PAIR:
            begin
                amt_a = GW'(1);
                amt_b = GW'(1);
                inc_m = chars_eq_reg;
                amt_o = chars_eq_reg ? '0 : GW'(1);
            end
            esib_pkg::OP_GAP_B:
            begin
                amt_b = gap_reg;
                amt_o = gap_reg;
            end
            esib_pkg::OP_GAP_A:
            begin
                amt_a = gap_reg;
                amt_o = gap_reg;
            end
            default:
            begin
                amt_a = '0;
            end
        endcase
    end

    // saturating adders
    assign sum_a     = AW'(offset_a_reg) + AW'(amt_a);
    assign sum_b     = AW'(offset_b_reg) + AW'(amt_b);
    assign sum_o     = OAW'(other_reg) + OAW'(amt_o);
    assign offa_sat  = (sum_a > AW'({PW{1'b1}})) ? {PW{1'b1}} : sum_a[PW-1:0];
    assign offb_sat  = (sum_b > AW'({PW{1'b1}})) ? {PW{1'b1}} : sum_b[PW-1:0];
    assign other_sat = (sum_o > OAW'({OCW{1'b1}})) ? {OCW{1'b1}} : sum_o[OCW-1:0];
    assign match_sat = (inc_m && !(&match_reg)) ? match_reg + PW'(1) : match_reg;

    assign last_taken = res.valid && res.ready && (idx_reg == cnt_reg - CW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            esib_pkg::ST_IDLE:
                if (op.valid)
                    state_next = esib_pkg::ST_CHECK_PRE;
            esib_pkg::ST_CHECK_PRE:
                if (start_sum)
                    state_next = esib_pkg::ST_DIV;
                else if (summary_done_reg)
                    state_next = esib_pkg::ST_EMIT;
                else
                    state_next = esib_pkg::ST_APPLY;
            esib_pkg::ST_APPLY:
                state_next = esib_pkg::ST_CHECK_POST;
            esib_pkg::ST_CHECK_POST:
                state_next = start_sum ? esib_pkg::ST_DIV : esib_pkg::ST_EMIT;
            esib_pkg::ST_DIV:
                if (div_done)
                    state_next = esib_pkg::ST_EMIT;
            esib_pkg::ST_EMIT:
                if (cnt_reg == '0 || last_taken)
                    state_next = esib_pkg::ST_IDLE;
            default:
                state_next = esib_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs of each state
    always_comb
    begin
        op_kind_next      = op_kind_reg;
        gap_next          = gap_reg;
        chars_eq_next     = chars_eq_reg;
        base_a_next       = base_a_reg;
        base_b_next       = base_b_reg;
        len_a_next        = len_a_reg;
        len_b_next        = len_b_reg;
        offset_a_next     = offset_a_reg;
        offset_b_next     = offset_b_reg;
        match_next        = match_reg;
        other_next        = other_reg;
        in_run_next       = in_run_reg;
        blocks_done_next  = blocks_done_reg;
        summary_done_next = summary_done_reg;
        cnt_next          = cnt_reg;
        idx_next          = idx_reg;
        ident_next        = ident_reg;
        acc_next          = acc_reg;
        push              = 1'b0;
        push_kind         = esib_pkg::RK_RUN;
        div_start         = 1'b0;
        case (state_reg)
            esib_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                idx_next = '0;
                if (op.valid)
                begin
                    op_kind_next  = op.op_kind;
                    gap_next      = op.gap_length;
                    chars_eq_next = op.char_a == op.char_b;
                    if (op.new_alignment)
                    begin
                        base_a_next       = op.base_a;
                        base_b_next       = op.base_b;
                        len_a_next        = op.len_a;
                        len_b_next        = op.len_b;
                        offset_a_next     = '0;
                        offset_b_next     = '0;
                        match_next        = '0;
                        other_next        = '0;
                        in_run_next       = 1'b0;
                        blocks_done_next  = 1'b0;
                        summary_done_next = 1'b0;
                    end
                end
            end
            esib_pkg::ST_CHECK_PRE, esib_pkg::ST_CHECK_POST:
            begin
                if (!blocks_done_reg && (ea || eb))
                begin
                    push             = 1'b1;
                    push_kind        = esib_pkg::RK_END;
                    cnt_next         = cnt_reg + CW'(1);
                    blocks_done_next = 1'b1;
                end
                if (start_sum)
                begin
                    div_start         = 1'b1;
                    summary_done_next = 1'b1;
                end
            end
            esib_pkg::ST_APPLY:
            begin
                offset_a_next = offa_sat;
                offset_b_next = offb_sat;
                match_next    = match_sat;
                other_next    = other_sat;
                if (op_kind_reg == esib_pkg::OP_PAIR)
                begin
                    in_run_next = 1'b1;
                    if (!blocks_done_reg && !in_run_reg)
                    begin
                        push      = 1'b1;
                        push_kind = esib_pkg::RK_RUN;
                        cnt_next  = cnt_reg + CW'(1);
                    end
                end
                else if (op_kind_reg == esib_pkg::OP_GAP_A ||
                         op_kind_reg == esib_pkg::OP_GAP_B)
                begin
                    in_run_next = 1'b0;
                end
            end
            esib_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    push       = 1'b1;
                    push_kind  = esib_pkg::RK_SUMMARY;
                    cnt_next   = cnt_reg + CW'(1);
                    ident_next = div_quot;
                    acc_next   = (div_quot >= min_identity) &&
                                 (LW'(len_a_reg) >= LW'(min_length)) &&
                                 (LW'(len_b_reg) >= LW'(min_length));
                end
            end
            esib_pkg::ST_EMIT:
            begin
                if (res.valid && res.ready)
                    idx_next = idx_reg + CW'(1);
                if (cnt_reg == '0 || last_taken)
                    cnt_next = '0;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // control and alignment state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= esib_pkg::ST_IDLE;
            base_a_reg       <= '0;
            base_b_reg       <= '0;
            len_a_reg        <= '0;
            len_b_reg        <= '0;
            offset_a_reg     <= '0;
            offset_b_reg     <= '0;
            match_reg        <= '0;
            other_reg        <= '0;
            in_run_reg       <= 1'b0;
            blocks_done_reg  <= 1'b0;
            summary_done_reg <= 1'b0;
            cnt_reg          <= '0;
            idx_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            base_a_reg       <= base_a_next;
            base_b_reg       <= base_b_next;
            len_a_reg        <= len_a_next;
            len_b_reg        <= len_b_next;
            offset_a_reg     <= offset_a_next;
            offset_b_reg     <= offset_b_next;
            match_reg        <= match_next;
            other_reg        <= other_next;
            in_run_reg       <= in_run_next;
            blocks_done_reg  <= blocks_done_next;
            summary_done_reg <= summary_done_next;
            cnt_reg          <= cnt_next;
            idx_reg          <= idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_kind_reg  <= op_kind_next;
        gap_reg      <= gap_next;
        chars_eq_reg <= chars_eq_next;
        ident_reg    <= ident_next;
        acc_reg      <= acc_next;
        if (push)
        begin
            kind_buf[cnt_reg] <= push_kind;
            pa_buf[cnt_reg]   <= pos_a_now;
            pb_buf[cnt_reg]   <= pos_b_now;
        end
    end

    // handshakes and result fields
    assign op.ready        = state_reg == esib_pkg::ST_IDLE;
    assign res.valid       = (state_reg == esib_pkg::ST_EMIT) && (cnt_reg != '0);
    assign res.result_kind = kind_buf[idx_reg];
    assign res.pos_a       = pa_buf[idx_reg];
    assign res.pos_b       = pb_buf[idx_reg];
    assign res.identity    = (kind_buf[idx_reg] == esib_pkg::RK_SUMMARY) ? ident_reg : '0;
    assign res.accepted    = (kind_buf[idx_reg] == esib_pkg::RK_SUMMARY) ? acc_reg : 1'b0;
    assign res.last_of_run = idx_reg == cnt_reg - CW'(1);

    assign div_matches = match_reg;
    assign div_others  = other_reg;

    // divider is started only from an exhaustion check
    a_div_start_src: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (state_reg == esib_pkg::ST_CHECK_PRE ||
                       state_reg == esib_pkg::ST_CHECK_POST))
        else $error("divider started outside an exhaustion check");

    // a new request only finds an empty result buffer
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        op.ready |-> cnt_reg == '0)
        else $error("result buffer not empty while taking a request");

    // a summary result only after the summary flag is set
    a_summary_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.result_kind == esib_pkg::RK_SUMMARY) |-> summary_done_reg)
        else $error("summary shown without summary flag");

    // the quotient is collected and results follow
    a_div_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |=> state_reg == esib_pkg::ST_EMIT)
        else $error("divider result not collected");

endmodule

### verif/tb_top.sv
// self-checking testbench of the edit script identity and run anchor block
`timescale 1ns / 1ps

module tb_top;

    localparam int PB             = 24;
    localparam int KW             = esib_pkg::KIND_W;
    localparam int GW             = esib_pkg::GAP_W;
    localparam int CHW            = esib_pkg::CHAR_W;
    localparam int IDW            = esib_pkg::ID_W;
    localparam int DATW           = esib_pkg::CFG_DATA_W;
    localparam longint unsigned POS_MAX   = (64'd1 << (PB + 1)) - 1;
    localparam longint unsigned OTHER_MAX = (64'd1 << (PB + 2)) - 1;
    localparam logic [PB-1:0] SEG_LIMIT   = '1;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_WALK_STEPS = 48;

    // op code with no operation behind it
    localparam logic [KW-1:0] OP_NONE = 2'd3;

    typedef struct {
        logic [KW-1:0]     op_kind;
        logic [GW-1:0]     gap_length;
        logic [CHW-1:0]    char_a;
        logic [CHW-1:0]    char_b;
        logic [PB-1:0]     base_a;
        logic [PB-1:0]     base_b;
        logic [PB-1:0]     len_a;
        logic [PB-1:0]     len_b;
        logic              new_alignment;
    } edit_op_t;

    typedef struct {
        esib_pkg::res_kind_t kind;
        logic [PB:0]         pos_a;
        logic [PB:0]         pos_b;
        logic [IDW-1:0]      identity;
        logic                accepted;
        logic                last_of_run;
    } walk_result_t;

    logic clk;
    logic rst_n;

    esib_op_if  #(.POSITION_BITS(PB)) op_ch ();
    esib_res_if #(.POSITION_BITS(PB)) res_ch ();
    esib_cfg_if                       cfg_ch ();

    edit_script_identity_and_blocks_core #(.POSITION_BITS(PB)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // tracked walker state and thresholds
    longint unsigned trk_off_a, trk_off_b, trk_match, trk_other;
    longint unsigned trk_base_a, trk_base_b, trk_len_a, trk_len_b;
    bit              trk_in_run, trk_ends_done, trk_summary_done;
    logic [IDW-1:0]                     thr_identity;
    logic [esib_pkg::MIN_LEN_W-1:0]     thr_length;

    walk_result_t expected_results[$];
    walk_result_t step_results[$];

    int  mismatches;
    int  ops_counted;
    int  sender_idle_pct;
    int  recv_stall_pct;
    int  cycle_count;
    bit  hold_req;
    bit  hold_on;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                                 longint unsigned lim);
        longint unsigned s;
        s = a + b;
        return (s > lim) ? lim : s;
    endfunction

    // one result at the current positions
    function automatic void push_result(esib_pkg::res_kind_t k, logic [IDW-1:0] ident,
                                        logic acc);
        walk_result_t r;
        r.kind        = k;
        r.pos_a       = (PB + 1)'(sat_sum(trk_base_a, trk_off_a, POS_MAX));
        r.pos_b       = (PB + 1)'(sat_sum(trk_base_b, trk_off_b, POS_MAX));
        r.identity    = ident;
        r.accepted    = acc;
        r.last_of_run = 1'b0;
        step_results.push_back(r);
    endfunction

    // end anchor when either side runs out, summary when both do
    function automatic void close_checks();
        bit              out_a;
        bit              out_b;
        longint unsigned total;
        logic [IDW-1:0]  ident;
        logic            acc;
        out_a = trk_off_a >= trk_len_a;
        out_b = trk_off_b >= trk_len_b;
        if (!trk_ends_done && (out_a || out_b))
        begin
            push_result(esib_pkg::RK_END, '0, 1'b0);
            trk_ends_done = 1'b1;
        end
        if (!trk_summary_done && out_a && out_b)
        begin
            total = trk_match + trk_other;
            ident = (total != 0) ? IDW'((trk_match << 16) / total) : '0;
            acc   = (ident >= thr_identity) && (trk_len_a >= thr_length) &&
                    (trk_len_b >= thr_length);
            push_result(esib_pkg::RK_SUMMARY, ident, acc);
            trk_summary_done = 1'b1;
        end
    endfunction

    // expected results of one edit operation
    function automatic void predict_walk(edit_op_t it);
        step_results.delete();
        if (it.new_alignment)
        begin
            trk_base_a       = it.base_a;
            trk_base_b       = it.base_b;
            trk_len_a        = it.len_a;
            trk_len_b        = it.len_b;
            trk_off_a        = 0;
            trk_off_b        = 0;
            trk_match        = 0;
            trk_other        = 0;
            trk_in_run       = 1'b0;
            trk_ends_done    = 1'b0;
            trk_summary_done = 1'b0;
        end
        close_checks();
        if (!trk_summary_done)
        begin
            case (it.op_kind)
                esib_pkg::OP_PAIR:
                begin
                    if (!trk_ends_done && !trk_in_run)
                        push_result(esib_pkg::RK_RUN, '0, 1'b0);
                    trk_in_run = 1'b1;
                    if (it.char_a == it.char_b)
                        trk_match = sat_sum(trk_match, 1, POS_MAX);
                    else
                        trk_other = sat_sum(trk_other, 1, OTHER_MAX);
                    trk_off_a = sat_sum(trk_off_a, 1, POS_MAX);
                    trk_off_b = sat_sum(trk_off_b, 1, POS_MAX);
                end
                esib_pkg::OP_GAP_B:
                begin
                    trk_in_run = 1'b0;
                    trk_other  = sat_sum(trk_other, it.gap_length, OTHER_MAX);
                    trk_off_b  = sat_sum(trk_off_b, it.gap_length, POS_MAX);
                end
                esib_pkg::OP_GAP_A:
                begin
                    trk_in_run = 1'b0;
                    trk_other  = sat_sum(trk_other, it.gap_length, OTHER_MAX);
                    trk_off_a  = sat_sum(trk_off_a, it.gap_length, POS_MAX);
                end
                default:
                begin
                end
            endcase
            close_checks();
        end
        if (step_results.size() > 0)
            step_results[$].last_of_run = 1'b1;
        foreach (step_results[i])
            expected_results.push_back(step_results[i]);
    endfunction

    function automatic edit_op_t make_op(bit na, logic [KW-1:0] kind,
                                         logic [GW-1:0] gap,
                                         logic [CHW-1:0] ca, logic [CHW-1:0] cb,
                                         logic [PB-1:0] ba, logic [PB-1:0] bb,
                                         logic [PB-1:0] la, logic [PB-1:0] lb);
        edit_op_t it;
        it.new_alignment = na;
        it.op_kind       = kind;
        it.gap_length    = gap;
        it.char_a        = ca;
        it.char_b        = cb;
        it.base_a        = ba;
        it.base_b        = bb;
        it.len_a         = la;
        it.len_b         = lb;
        return it;
    endfunction

    // fully random operation of the given kind
    function automatic edit_op_t random_op(bit na, logic [KW-1:0] kind);
        return make_op(na, kind, GW'($urandom), CHW'($urandom), CHW'($urandom),
                       PB'($urandom), PB'($urandom), PB'($urandom), PB'($urandom));
    endfunction

    // send one edit operation request, with random idle cycles first
    task automatic send_edit_op(edit_op_t it);
        bit ignored;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            @(negedge clk);
            op_ch.valid <= 1'b0;
        end
        @(negedge clk);
        op_ch.valid         <= 1'b1;
        op_ch.op_kind       <= it.op_kind;
        op_ch.gap_length    <= it.gap_length;
        op_ch.char_a        <= it.char_a;
        op_ch.char_b        <= it.char_b;
        op_ch.base_a        <= it.base_a;
        op_ch.base_b        <= it.base_b;
        op_ch.len_a         <= it.len_a;
        op_ch.len_b         <= it.len_b;
        op_ch.new_alignment <= it.new_alignment;
        do
            @(posedge clk);
        while (op_ch.ready !== 1'b1);
        ignored = trk_summary_done && !it.new_alignment;
        predict_walk(it);
        if (!ignored)
            ops_counted++;
    endtask

    // drop valid and wait until the block has drained
    task automatic settle();
        @(negedge clk);
        op_ch.valid <= 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one threshold register write
    task automatic write_threshold(logic [esib_pkg::CFG_IDX_W-1:0] idx,
                                   logic [DATW-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        if (idx == esib_pkg::REG_MIN_IDENTITY)
            thr_identity = value[IDW-1:0];
        else
            thr_length = value[esib_pkg::MIN_LEN_W-1:0];
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly short segments, some empty, a few of any length
    function automatic logic [PB-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return PB'($urandom);
        return PB'($urandom_range(1, 20));
    endfunction

    // one alignment walked with random content, sometimes cut short
    task automatic walk_random_alignment();
        edit_op_t      it;
        int            rem_a;
        int            rem_b;
        int            rem;
        int            steps;
        int            pick;
        int            g;
        bit            side_a;
        logic [PB-1:0] la;
        logic [PB-1:0] lb;
        la    = pick_length();
        lb    = pick_length();
        rem_a = la;
        rem_b = lb;
        steps = 0;
        do
        begin
            pick = $urandom_range(0, 99);
            it = random_op(steps == 0, OP_NONE);
            if (steps == 0)
            begin
                it.len_a = la;
                it.len_b = lb;
            end
            if (pick < 4)
            begin
                it.op_kind = OP_NONE;
            end
            else if (pick < 10 || (pick < 75 && rem_a > 0 && rem_b > 0))
            begin
                it.op_kind = esib_pkg::OP_PAIR;
                if ($urandom_range(0, 99) < 65)
                    it.char_b = it.char_a;
                rem_a--;
                rem_b--;
            end
            else
            begin
                // gap on a side that still has room, sometimes overshooting
                side_a = (rem_b <= 0) || (rem_a > 0 && $urandom_range(0, 1) == 1);
                rem    = side_a ? rem_a : rem_b;
                g      = (pick < 14) ? 0 : $urandom_range(0, (rem > 0) ? rem : 0);
                if ($urandom_range(0, 9) == 0)
                    g += $urandom_range(1, 3);
                if (g > int'(SEG_LIMIT))
                    g = int'(SEG_LIMIT);
                it.gap_length = GW'(g);
                if (side_a)
                begin
                    it.op_kind = esib_pkg::OP_GAP_A;
                    rem_a -= g;
                end
                else
                begin
                    it.op_kind = esib_pkg::OP_GAP_B;
                    rem_b -= g;
                end
            end
            send_edit_op(it);
            steps++;
        end
        while ((rem_a > 0 || rem_b > 0) && steps < MAX_WALK_STEPS &&
               $urandom_range(0, 99) >= 2);
        // stray operation after the walk
        if ($urandom_range(0, 9) == 0)
            send_edit_op(random_op(1'b0, KW'($urandom)));
    endtask

    // empty segments right after reset and on a new alignment
    task automatic test_reset_exhausted();
        send_edit_op(make_op(1'b0, esib_pkg::OP_PAIR, 0, 8'h00, 8'h00, 0, 0, 0, 0));
        send_edit_op(make_op(1'b0, esib_pkg::OP_GAP_A, SEG_LIMIT, 8'hFF, 8'h00,
                             0, 0, 0, 0));
        send_edit_op(make_op(1'b1, OP_NONE, 0, 8'h00, 8'h00,
                             PB'($urandom), PB'($urandom), 0, 0));
    endtask

    // run anchors, mismatch, zero-length gap, no-op, three results at once
    task automatic test_run_anchors();
        send_edit_op(make_op(1'b1, esib_pkg::OP_PAIR, 0, 8'hFF, 8'hFF,
                             SEG_LIMIT, 0, 3, 3));
        send_edit_op(make_op(1'b0, esib_pkg::OP_PAIR, 0, 8'h00, 8'hFF, 0, 0, 0, 0));
        send_edit_op(make_op(1'b0, esib_pkg::OP_GAP_B, 0, 8'h00, 8'h00, 0, 0, 0, 0));
        send_edit_op(make_op(1'b0, OP_NONE, SEG_LIMIT, 8'h12, 8'h12, 0, 0, 0, 0));
        send_edit_op(make_op(1'b0, esib_pkg::OP_PAIR, 0, 8'h55, 8'h55, 0, 0, 0, 0));
    endtask

    // counting goes on after the end anchor, then ignored after the summary
    task automatic test_counting_after_end();
        send_edit_op(make_op(1'b1, esib_pkg::OP_GAP_A, 2, 8'h00, 8'h00,
                             PB'($urandom), PB'($urandom), 2, 5));
        send_edit_op(make_op(1'b0, esib_pkg::OP_PAIR, 0, 8'hAB, 8'hAB, 0, 0, 0, 0));
        send_edit_op(make_op(1'b0, esib_pkg::OP_GAP_B, 10, 8'h00, 8'h00, 0, 0, 0, 0));
        send_edit_op(make_op(1'b0, esib_pkg::OP_PAIR, 0, 8'h01, 8'h01, 0, 0, 0, 0));
    endtask

    // offsets, positions and the other count run into their limits
    task automatic test_saturation();
        send_edit_op(make_op(1'b1, esib_pkg::OP_PAIR, 0, 8'h3C, 8'h3C,
                             SEG_LIMIT, SEG_LIMIT, 1, SEG_LIMIT));
        repeat (4)
            send_edit_op(make_op(1'b0, esib_pkg::OP_GAP_A, SEG_LIMIT, 8'h00, 8'h00,
                                 0, 0, 0, 0));
        send_edit_op(make_op(1'b0, esib_pkg::OP_GAP_B, SEG_LIMIT, 8'h00, 8'h00,
                             0, 0, 0, 0));
    endtask

    // identity exactly at and just below the threshold, then full identity
    task automatic test_identity_threshold();
        logic [DATW-1:0]   limit_id;
        logic [CHW-1:0]    c;
        for (limit_id = 24'd43690; limit_id <= 24'd43691; limit_id++)
        begin
            settle();
            write_threshold(esib_pkg::REG_MIN_IDENTITY, limit_id);
            c = CHW'($urandom);
            send_edit_op(make_op(1'b1, esib_pkg::OP_PAIR, 0, c, c,
                                 PB'($urandom), PB'($urandom), 3, 3));
            send_edit_op(make_op(1'b0, esib_pkg::OP_PAIR, 0, ~c, ~c, 0, 0, 0, 0));
            send_edit_op(make_op(1'b0, esib_pkg::OP_PAIR, 0, c, ~c, 0, 0, 0, 0));
        end
        settle();
        write_threshold(esib_pkg::REG_MIN_IDENTITY, 24'h010000);
        write_threshold(esib_pkg::REG_MIN_LENGTH, 24'd1);
        send_edit_op(make_op(1'b1, esib_pkg::OP_PAIR, 0, 8'h7E, 8'h7E,
                             PB'($urandom), PB'($urandom), 1, 1));
    endtask

    // random walks under one threshold setting and one idling mode
    task automatic test_random_walks(int items, int sidle, int rstall,
                                     logic [DATW-1:0] min_id,
                                     logic [DATW-1:0] min_len);
        int target;
        settle();
        write_threshold(esib_pkg::REG_MIN_IDENTITY, min_id);
        write_threshold(esib_pkg::REG_MIN_LENGTH, min_len);
        sender_idle_pct = sidle;
        recv_stall_pct  = rstall;
        target = ops_counted + items;
        while (ops_counted < target)
            walk_random_alignment();
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        int target;
        settle();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_req = 1'b1;
        target = ops_counted + 24;
        while (ops_counted < target)
            walk_random_alignment();
    endtask

    // long receiver hold-off, counted here
    initial
    begin
        hold_on = 1'b0;
        forever
        begin
            wait (hold_req);
            hold_req = 1'b0;
            hold_on  = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on  = 1'b0;
        end
    end

    // result ready with random stalls
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= !hold_on && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // compare each result request with the oldest expectation
    always @(posedge clk)
    begin
        walk_result_t w;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result kind %0d at %0d/%0d with no expectation waiting",
                       res_ch.result_kind, res_ch.pos_a, res_ch.pos_b);
                mismatches++;
            end
            else
            begin
                w = expected_results.pop_front();
                check_field("result_kind", 32'(w.kind), 32'(res_ch.result_kind));
                check_field("pos_a", 32'(w.pos_a), 32'(res_ch.pos_a));
                check_field("pos_b", 32'(w.pos_b), 32'(res_ch.pos_b));
                check_field("identity", 32'(w.identity), 32'(res_ch.identity));
                check_field("accepted", 32'(w.accepted), 32'(res_ch.accepted));
                check_field("last_of_run", 32'(w.last_of_run), 32'(res_ch.last_of_run));
            end
        end
    end

    // cycle limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // sequence of tests
    initial
    begin
        mismatches       = 0;
        ops_counted      = 0;
        sender_idle_pct  = 0;
        recv_stall_pct   = 0;
        hold_req         = 1'b0;
        thr_identity     = '0;
        thr_length       = '0;
        trk_off_a        = 0;
        trk_off_b        = 0;
        trk_match        = 0;
        trk_other        = 0;
        trk_base_a       = 0;
        trk_base_b       = 0;
        trk_len_a        = 0;
        trk_len_b        = 0;
        trk_in_run       = 1'b0;
        trk_ends_done    = 1'b0;
        trk_summary_done = 1'b0;

        op_ch.valid         = 1'b0;
        op_ch.op_kind       = esib_pkg::OP_PAIR;
        op_ch.gap_length    = '0;
        op_ch.char_a        = '0;
        op_ch.char_b        = '0;
        op_ch.base_a        = '0;
        op_ch.base_b        = '0;
        op_ch.len_a         = '0;
        op_ch.len_b         = '0;
        op_ch.new_alignment = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = esib_pkg::REG_MIN_IDENTITY;
        cfg_ch.data         = '0;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_exhausted();
        test_run_anchors();
        test_counting_after_end();
        test_saturation();
        test_identity_threshold();

        test_random_walks(100, 0, 0, 24'd0, 24'd0);
        test_random_walks(100, 68, 0, 24'h010000, 24'd0);
        test_random_walks(100, 0, 68, DATW'($urandom_range(0, 65536)),
                          DATW'($urandom_range(0, 12)));
        test_random_walks(100, 14, 14, 24'd32768, 24'hFFFFFF);
        test_backpressure();

        settle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
